// ----- src/mcso_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and elaboration-time table builders for the MIDI-retuned sine oscillator.
// Depends on nothing; every module of the block imports it.
package mcso_pkg;

	// Default build parameters.
	localparam int unsigned DEFAULT_PHASE_BITS      = 32;
	localparam int unsigned DEFAULT_SINE_TABLE_BITS = 10;
	localparam int unsigned DEFAULT_SAMPLE_RATE     = 48000;

	// Item kinds carried by the action field.
	localparam logic ACTION_TICK = 1'b0;
	localparam logic ACTION_MIDI = 1'b1;

	// MIDI codes.
	localparam logic [7:0] STATUS_NOTE_ON = 8'd144;
	localparam int unsigned NOTE_A4       = 69;

	// Fixed-point constants.
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam int unsigned FULL_SCALE  = 32767;

	// Semitone ratios 2^(s/12) in Q24, rounded.
	localparam logic [31:0] SEMITONE_Q24 [12] = '{
		32'd16777216, 32'd17774841, 32'd18831788, 32'd19951585,
		32'd21137968, 32'd22394897, 32'd23726566, 32'd25137421,
		32'd26632170, 32'd28215802, 32'd29893600, 32'd31671166
	};

	// First-quadrant sine magnitude, floor(sin(j * pi/2 / 2^qshift) * 32767).
	// Taylor series through x^15 in Q30 with each term truncated.
	function automatic logic [14:0] quarter_sine(input int unsigned j, input int unsigned qshift);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] mag;
		logic [63:0] t;
		logic [63:0] scaled;
		longint      sum;
		x = (64'(j) * 64'(HALF_PI_Q30)) >> qshift;
		x2 = (x * x) >> 30;
		mag = x;
		sum = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			t = (mag * x2) >> 30;
			case (k)
				1: mag = t / 6;
				2: mag = t / 20;
				3: mag = t / 42;
				4: mag = t / 72;
				5: mag = t / 110;
				6: mag = t / 156;
				7: mag = t / 210;
				default: mag = '0;
			endcase
			if ((k & 1) != 0) begin
				sum = sum - longint'(mag);
			end else begin
				sum = sum + longint'(mag);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (longint'(1) << 30)) begin
			sum = longint'(1) << 30;
		end
		scaled = 64'(sum) * 64'(FULL_SCALE);
		return 15'(scaled >> 30);
	endfunction

	// Phase increment for a MIDI note, rounded half up; the caller truncates
	// it to the phase width, which wraps it modulo one turn.
	function automatic logic [63:0] note_increment(input int unsigned note,
			input int unsigned phase_bits, input int unsigned sample_rate);
		int unsigned m;
		int unsigned semi;
		int          octave;
		int          k;
		logic [63:0] a;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] rem;
		logic [63:0] quo;
		m = (note & 127) + 3;
		octave = int'(m / 12) - 6;
		semi = m % 12;
		a = 64'd440 * 64'(SEMITONE_Q24[semi]);
		k = int'(phase_bits) + octave - 23;
		if (k >= 0) begin
			num = a << k;
			den = 64'(sample_rate);
		end else begin
			num = a;
			den = 64'(sample_rate) << (-k);
		end
		// Restoring long division, one quotient bit per step.
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem = rem - den;
				quo[i] = 1'b1;
			end
		end
		return (quo + 64'd1) >> 1;
	endfunction

endpackage

// ----- src/mcso_phase.sv -----
`timescale 1ns / 1ps
// Phase accumulator and note-driven increment register with its note table.
// Depends on mcso_pkg.
module mcso_phase
	import mcso_pkg::*;
#(
	parameter int unsigned PHASE_BITS      = DEFAULT_PHASE_BITS,
	parameter int unsigned SINE_TABLE_BITS = DEFAULT_SINE_TABLE_BITS,
	parameter int unsigned SAMPLE_RATE     = DEFAULT_SAMPLE_RATE
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_fire,
	input  logic                       action,
	input  logic [7:0]                 status_byte,
	input  logic [6:0]                 note_number,
	input  logic [6:0]                 velocity,
	output logic                       tick_load,
	output logic [SINE_TABLE_BITS-1:0] tick_idx
);

	localparam int unsigned NOTE_COUNT = 128;
	localparam logic [PHASE_BITS-1:0] INC_RESET =
		PHASE_BITS'(note_increment(NOTE_A4, PHASE_BITS, SAMPLE_RATE));

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] inc_q;
	logic [PHASE_BITS-1:0] note_tab [NOTE_COUNT];
	logic                  note_on;

	// Note table, built at elaboration.
	for (genvar g = 0; g < NOTE_COUNT; g++) begin : g_note_tab
		assign note_tab[g] = PHASE_BITS'(note_increment(g, PHASE_BITS, SAMPLE_RATE));
	end

	// Decode of the accepted item.
	assign tick_load = in_fire && (action == ACTION_TICK);
	assign note_on   = in_fire && (action == ACTION_MIDI) &&
		(status_byte == STATUS_NOTE_ON) && (velocity != 7'd0);

	// The sine address is the top bits of the phase before this tick advances it.
	assign tick_idx = phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];

	// Accumulator advances on every tick; a note-on reloads the increment.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			inc_q   <= INC_RESET;
		end else begin
			if (tick_load) begin
				phase_q <= phase_q + inc_q;
			end
			if (note_on) begin
				inc_q <= note_tab[note_number];
			end
		end
	end

`ifndef SYNTH
	// The increment moves only on a note-on transfer with nonzero velocity.
	a_inc_only_on_note: assert property (@(posedge clk) disable iff (!arst_n)
		!note_on |=> $stable(inc_q))
		else $error("increment changed without a note-on");
	// The phase moves only on a tick transfer, and then by the increment.
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		tick_load |=> phase_q == $past(phase_q + inc_q))
		else $error("phase did not advance by the increment");
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_load |=> $stable(phase_q))
		else $error("phase changed without a tick");
`endif

endmodule

// ----- src/mcso_sine.sv -----
`timescale 1ns / 1ps
// Two-stage sine lookup: quarter-wave address fold, then ROM read and sign into the output register.
// Depends on mcso_pkg.
module mcso_sine
	import mcso_pkg::*;
#(
	parameter int unsigned SINE_TABLE_BITS = DEFAULT_SINE_TABLE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tick_load,
	input  logic [SINE_TABLE_BITS-1:0] tick_idx,
	output logic                       can_take,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [15:0]         sample
);

	localparam int unsigned QSHIFT  = SINE_TABLE_BITS - 2;
	localparam int unsigned QUARTER = 1 << QSHIFT;

	logic [14:0]       sine_tab [QUARTER + 1];
	logic [QSHIFT:0]   addr_fold;
	logic [QSHIFT:0]   addr_s1;
	logic              neg_s1;
	logic              valid_s1;
	logic              valid_s2;
	logic signed [15:0] sample_s2;
	logic signed [15:0] mag_ext;
	logic              stall;

	// Quarter-wave sine table, built at elaboration.
	for (genvar g = 0; g <= QUARTER; g++) begin : g_sine_tab
		assign sine_tab[g] = quarter_sine(g, QSHIFT);
	end

	// Odd quadrants read the quarter backwards; the upper half is negated later.
	always_comb begin
		if (tick_idx[QSHIFT]) begin
			addr_fold = (QSHIFT + 1)'(QUARTER) - {1'b0, tick_idx[QSHIFT-1:0]};
		end else begin
			addr_fold = {1'b0, tick_idx[QSHIFT-1:0]};
		end
	end

	// Flow control: the output register holds while its transfer is stalled.
	assign stall    = valid_s2 && !out_ready;
	assign can_take = !valid_s1 || !stall;

	// Stage one: folded address and sign.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (can_take) begin
			valid_s1 <= tick_load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && tick_load) begin
			addr_s1 <= addr_fold;
			neg_s1  <= tick_idx[SINE_TABLE_BITS-1];
		end
	end

	// Stage two: table read and sign into the output register.
	assign mag_ext = signed'({1'b0, sine_tab[addr_s1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && valid_s1) begin
			sample_s2 <= neg_s1 ? -mag_ext : mag_ext;
		end
	end

	assign out_valid = valid_s2;
	assign sample    = sample_s2;

`ifndef SYNTH
	// No tick is loaded while stage one is blocked.
	a_no_load_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		tick_load |-> can_take)
		else $error("tick loaded while stage one was blocked");
	// A held stage-one item keeps its address.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && stall |=> valid_s1 && $stable(addr_s1) && $stable(neg_s1))
		else $error("stage one lost its item during a stall");
	// A delivered sample with nothing behind it leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_ready && !valid_s1 |=> !valid_s2)
		else $error("sample repeated after its transfer");
	// The sample never reaches the most negative code.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> sample_s2 != 16'sh8000)
		else $error("sample out of range");
`endif

endmodule

// ----- src/midi_controlled_sine_oscillator.sv -----
`timescale 1ns / 1ps
// Top level of the MIDI-retuned direct digital synthesis sine oscillator.
// Depends on mcso_pkg, mcso_phase and mcso_sine.
//
// The block takes one item per clock cycle on the input channel. A tick
// item (action 0) produces one signed 16-bit sine sample through stage one and
// the output register, taken from a quarter-wave table addressed by the top
// bits of the phase accumulator, and then advances the phase by the current
// increment. A note-on item (status 144, nonzero velocity) loads the
// increment for its note from a table built at elaboration; the next tick
// already uses it. All other MIDI items produce nothing. The rate is set by
// the two-register lookup pipeline: in_ready falls only while the output
// sample waits for out_ready and stage one already holds the next tick.
module midi_controlled_sine_oscillator
	import mcso_pkg::*;
#(
	parameter int unsigned PHASE_BITS      = DEFAULT_PHASE_BITS,
	parameter int unsigned SINE_TABLE_BITS = DEFAULT_SINE_TABLE_BITS,
	parameter int unsigned SAMPLE_RATE     = DEFAULT_SAMPLE_RATE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [7:0]         status_byte,
	input  logic [6:0]         note_number,
	input  logic [6:0]         velocity,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample
);

	logic                       in_fire;
	logic                       tick_load;
	logic [SINE_TABLE_BITS-1:0] tick_idx;
	logic                       can_take;

	// Input transfer.
	assign in_ready = can_take;
	assign in_fire  = in_valid && in_ready;

	// Phase and increment state.
	mcso_phase #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.SAMPLE_RATE     (SAMPLE_RATE)
	) u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.action      (action),
		.status_byte (status_byte),
		.note_number (note_number),
		.velocity    (velocity),
		.tick_load   (tick_load),
		.tick_idx    (tick_idx)
	);

	// Sine lookup and output register.
	mcso_sine #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_sine (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_load (tick_load),
		.tick_idx  (tick_idx),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample)
	);

endmodule

// ----- dv/mcso_sample_checker.sv -----
`timescale 1ns / 1ps
// Sample checker for the MIDI-retuned sine oscillator testbench: watches both channels,
// predicts every sample from its own phase model and compares it. Depends on mcso_pkg.
module mcso_sample_checker
	import mcso_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               action,
	input  logic [7:0]         status_byte,
	input  logic [6:0]         note_number,
	input  logic [6:0]         velocity,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] sample,
	output int                 errors,
	output int                 pending
);

	localparam int unsigned TABLE_BITS = 10;
	localparam int unsigned QUARTER_LOG = TABLE_BITS - 2;
	localparam int unsigned ACC_BITS = 32;
	localparam int unsigned RATE_HZ = 48000;

	logic signed [15:0] sine_table [1 << TABLE_BITS];
	logic [ACC_BITS-1:0] model_phase;
	logic [ACC_BITS-1:0] model_increment;
	logic signed [15:0] expected_samples [$];
	int                 err_count = 0;

	// Equal-tempered ratio 2^(s/12) in Q24.
	function automatic logic [31:0] semitone_ratio(input int unsigned s);
		case (s)
			0: return 32'd16777216;
			1: return 32'd17774841;
			2: return 32'd18831788;
			3: return 32'd19951585;
			4: return 32'd21137968;
			5: return 32'd22394897;
			6: return 32'd23726566;
			7: return 32'd25137421;
			8: return 32'd26632170;
			9: return 32'd28215802;
			10: return 32'd29893600;
			default: return 32'd31671166;
		endcase
	endfunction

	// First-quadrant sine magnitude in sample units, Taylor series in Q30 radians.
	function automatic logic [14:0] sine_magnitude(input int unsigned step);
		logic [63:0] angle;
		logic [63:0] angle_sq;
		logic [63:0] term;
		longint      acc;
		angle = (64'(step) * 64'(HALF_PI_Q30)) >> QUARTER_LOG;
		angle_sq = (angle * angle) >> 30;
		term = angle;
		acc = longint'(angle);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * angle_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > (longint'(1) << 30)) begin
			acc = longint'(1) << 30;
		end
		return 15'((64'(acc) * 64'd32767) >> 30);
	endfunction

	// Phase step for a note: 440 Hz * ratio * 2^(ACC_BITS + octave) / rate, rounded half up.
	// The octave offset keeps the shift positive for every note at this width.
	function automatic logic [ACC_BITS-1:0] tone_increment(input int unsigned note);
		int unsigned shifted;
		logic [63:0] numer;
		shifted = (note & 127) + 3;
		numer = (64'd440 * 64'(semitone_ratio(shifted % 12))) << (ACC_BITS + shifted / 12 - 29);
		return ACC_BITS'(((numer / 64'(RATE_HZ)) + 64'd1) >> 1);
	endfunction

	// Full-wave table from quarter-wave symmetry.
	initial begin
		logic [1:0]  quad;
		int unsigned offs;
		logic [15:0] mag;
		for (int i = 0; i < (1 << TABLE_BITS); i++) begin
			quad = 2'(i >> QUARTER_LOG);
			offs = i & ((1 << QUARTER_LOG) - 1);
			mag = {1'b0, sine_magnitude(quad[0] ? (1 << QUARTER_LOG) - offs : offs)};
			sine_table[i] = quad[1] ? -$signed(mag) : $signed(mag);
		end
	end

	// Compare sample transfers in order and advance the model on each input transfer.
	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] want;
		if (!arst_n) begin
			model_phase = '0;
			model_increment = tone_increment(NOTE_A4);
			expected_samples.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					err_count++;
					$display("%0t: unexpected sample, expected none, got %0d", $time, sample);
				end else begin
					want = expected_samples.pop_front();
					if (sample !== want) begin
						err_count++;
						$display("%0t: sample mismatch, expected %0d, got %0d",
							$time, want, sample);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (action == ACTION_TICK) begin
					expected_samples.push_back(sine_table[model_phase[ACC_BITS-1 -: TABLE_BITS]]);
					model_phase = model_phase + model_increment;
				end else if (status_byte == STATUS_NOTE_ON && velocity != 7'd0) begin
					model_increment = tone_increment(note_number);
				end
			end
			pending <= expected_samples.size();
		end
		errors <= err_count;
	end

endmodule

// ----- dv/midi_controlled_sine_oscillator_tb.sv -----
`timescale 1ns / 1ps
// Top of the MIDI-retuned sine oscillator testbench: clock, reset, stimulus and verdict.
// Depends on mcso_pkg, the oscillator RTL and mcso_sample_checker.
module midi_controlled_sine_oscillator_tb;
	import mcso_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int HOLD_CYCLES = 300;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               action;
	logic [7:0]         status_byte;
	logic [6:0]         note_number;
	logic [6:0]         velocity;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] sample;
	int                 errors;
	int                 pending;
	logic               hold_request;

	midi_controlled_sine_oscillator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.status_byte(status_byte),
		.note_number(note_number),
		.velocity(velocity),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample)
	);

	mcso_sample_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.status_byte(status_byte),
		.note_number(note_number),
		.velocity(velocity),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one item and hold it until its transfer; valid stays high afterwards.
	task automatic send_item(input logic act, input logic [7:0] st, input logic [6:0] nt,
			input logic [6:0] vel);
		in_valid <= 1'b1;
		action <= act;
		status_byte <= st;
		note_number <= nt;
		velocity <= vel;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drop valid for a gap, with junk on the payload.
	task automatic pause_input(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			action <= 1'($urandom);
			status_byte <= 8'($urandom);
			note_number <= 7'($urandom);
			velocity <= 7'($urandom);
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Stop offering items until every predicted sample has come out.
	task automatic wait_for_samples();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Mostly ticks with junk fields, a fair share of note-ons, some other MIDI traffic.
	task automatic send_random_item();
		int pick;
		logic [6:0] vel;
		pick = $urandom_range(99);
		if (pick < 78) begin
			send_item(ACTION_TICK, 8'($urandom), 7'($urandom), 7'($urandom));
		end else if (pick < 92) begin
			vel = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(127, 1));
			send_item(ACTION_MIDI, STATUS_NOTE_ON, 7'($urandom), vel);
		end else begin
			send_item(ACTION_MIDI, 8'($urandom), 7'($urandom), 7'($urandom));
		end
	endtask

	// Receiver: modes of random length, plus one long hold-off on request.
	initial begin
		int mode;
		int span;
		int beat;
		bit hold_served;
		out_ready <= 1'b0;
		beat = 0;
		hold_served = 1'b0;
		forever begin
			mode = $urandom_range(3);
			span = $urandom_range(80, 10);
			repeat (span) begin
				@(posedge clk);
				beat++;
				if (hold_request && !hold_served) begin
					hold_served = 1'b1;
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end else begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom);
						2: out_ready <= (beat % 4) != 0;
						default: out_ready <= ($urandom_range(4) == 0);
					endcase
				end
			end
		end
	end

	// Reset, directed items, random bursts, then the verdict.
	initial begin
		int sent;
		int burst;
		int gap;
		bit hold_done;
		bit drain_done;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		hold_request <= 1'b0;
		action <= ACTION_TICK;
		status_byte <= 8'd0;
		note_number <= 7'd0;
		velocity <= 7'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ticks from reset, extreme notes, note-off forms and other status codes.
		repeat (3) send_item(ACTION_TICK, 8'd0, 7'd0, 7'd0);
		send_item(ACTION_MIDI, STATUS_NOTE_ON, 7'd127, 7'd127);
		repeat (3) send_item(ACTION_TICK, 8'd0, 7'd0, 7'd0);
		send_item(ACTION_MIDI, STATUS_NOTE_ON, 7'd0, 7'd1);
		repeat (2) send_item(ACTION_TICK, 8'd0, 7'd0, 7'd0);
		// Note-on with zero velocity acts as note-off and leaves the tone alone.
		send_item(ACTION_MIDI, STATUS_NOTE_ON, 7'd127, 7'd0);
		send_item(ACTION_TICK, 8'd0, 7'd0, 7'd0);
		send_item(ACTION_MIDI, 8'd128, 7'd69, 7'd64);
		send_item(ACTION_MIDI, 8'd255, 7'd127, 7'd127);
		send_item(ACTION_MIDI, 8'd0, 7'd0, 7'd0);
		send_item(ACTION_MIDI, 8'd145, 7'd100, 7'd50);
		// Tick fields other than action are ignored.
		send_item(ACTION_TICK, 8'd255, 7'd127, 7'd127);
		send_item(ACTION_MIDI, STATUS_NOTE_ON, 7'(NOTE_A4), 7'd64);
		repeat (3) send_item(ACTION_TICK, 8'd144, 7'd0, 7'd1);
		wait_for_samples();

		sent = 0;
		hold_done = 1'b0;
		drain_done = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(24, 1);
			repeat (burst) begin
				send_random_item();
				sent++;
			end
			// Stall the output for a long stretch while ticks keep coming.
			if (!hold_done && sent >= 650) begin
				hold_done = 1'b1;
				hold_request <= 1'b1;
				repeat (40) send_item(ACTION_TICK, 8'($urandom), 7'($urandom), 7'($urandom));
			end
			if (!drain_done && sent >= 1300) begin
				drain_done = 1'b1;
				wait_for_samples();
			end
			if (sent >= 900 && sent < 1100) begin
				gap = 0;
			end else if ($urandom_range(3) == 0) begin
				gap = 0;
			end else begin
				gap = $urandom_range(6, 1);
			end
			pause_input(gap);
		end

		wait_for_samples();
		repeat (8) @(posedge clk);
		if (pending != 0) begin
			$display("%0t: %0d predicted samples never arrived", $time, pending);
		end
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- midi_controlled_sine_oscillator.f -----
src/mcso_pkg.sv
src/mcso_phase.sv
src/mcso_sine.sv
src/midi_controlled_sine_oscillator.sv
dv/mcso_sample_checker.sv
dv/midi_controlled_sine_oscillator_tb.sv
